// ===== hw/rtl/multi_window_mean_core_macros.svh =====
// assertion macros for the port-level checker file
`ifndef MULTI_WINDOW_MEAN_CORE_MACROS_SVH
`define MULTI_WINDOW_MEAN_CORE_MACROS_SVH

// antecedent implies consequent in the same cycle, quiet during reset
`define MWM_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("multi_window_mean_core assertion failed");

// antecedent implies consequent in the next cycle, quiet during reset
`define MWM_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("multi_window_mean_core assertion failed");

// antecedent implies consequent in the next cycle, also checked across reset
`define MWM_ASSERT_RESET(label, ante, cons) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("multi_window_mean_core assertion failed");

`endif

// ===== hw/rtl/mwm_pkg.sv =====
// types, constants and reciprocal table for the multi-window mean core
package mwm_pkg;

  localparam int MAX_WINDOW = 8;
  localparam int WEIGHT_W   = 16;
  localparam int LEN_W      = 4;
  localparam int BACK_W     = 3;
  localparam int SUM_W      = 20;
  localparam int NUM_W      = 19;
  localparam int RECIP_W    = 23;
  localparam int RECIP_SH   = 22;
  localparam int PROD_W     = NUM_W + RECIP_W;

  localparam logic CFG_SHORTEST = 1'b0;
  localparam logic CFG_LONGEST  = 1'b1;

  typedef struct packed {
    logic signed [WEIGHT_W-1:0] weight;
    logic                       ends_sequence;
  } in_item_t;

  typedef struct packed {
    logic signed [WEIGHT_W-1:0] mean;
    logic [LEN_W-1:0]           window_length;
    logic                       last_of_run;
  } out_item_t;

  typedef enum logic {
    ST_IDLE,
    ST_RUN
  } ctrl_state_t;

  typedef struct packed {
    logic load;
    logic step;
  } ctrl_cmd_t;

  typedef struct packed {
    logic work;
    logic final_step;
    logic advance;
  } dp_status_t;

  typedef struct packed {
    logic                    valid;
    logic signed [SUM_W-1:0] sum;
    logic [LEN_W-1:0]        len;
    logic                    last;
  } div_req_t;

  // ceil(2^22 / k), exact floor division for numerators below 2^19
  function automatic logic [RECIP_W-1:0] recip(input logic [LEN_W-1:0] k);
    logic [RECIP_W-1:0] r;
    case (k)
      4'd1:    r = 23'd4194304;
      4'd2:    r = 23'd2097152;
      4'd3:    r = 23'd1398102;
      4'd4:    r = 23'd1048576;
      4'd5:    r = 23'd838861;
      4'd6:    r = 23'd699051;
      4'd7:    r = 23'd599187;
      4'd8:    r = 23'd524288;
      default: r = '0;
    endcase
    return r;
  endfunction

endpackage

// ===== hw/rtl/mwm_stream_if.sv =====
// valid/ready stream interface carrying one packed payload
interface mwm_stream_if #(parameter type T = logic);
  logic valid;
  logic ready;
  T     payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

// ===== hw/rtl/mwm_ctrl.sv =====
// controller state machine sequencing load and window steps
module mwm_ctrl import mwm_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  input  dp_status_t status,
  output ctrl_cmd_t  cmd,
  output logic       ready
);

  ctrl_state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (in_valid && status.work) state_next = ST_RUN;
      end
      ST_RUN: begin
        if (status.advance && status.final_step) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd.load = 1'b0;
    cmd.step = 1'b0;
    ready    = 1'b0;
    case (state)
      ST_IDLE: begin
        ready    = 1'b1;
        cmd.load = in_valid;
      end
      ST_RUN: begin
        cmd.step = status.advance;
      end
      default: begin
        ready = 1'b0;
      end
    endcase
  end

endmodule

// ===== hw/rtl/mwm_datapath.sv =====
// weight history, config registers and window sum accumulator
module mwm_datapath import mwm_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_we,
  input  logic             cfg_index,
  input  logic [LEN_W-1:0] cfg_data,
  input  in_item_t         item,
  input  ctrl_cmd_t        cmd,
  input  logic             advance,
  output dp_status_t       status,
  output div_req_t         req
);

  logic [LEN_W-1:0]           shortest_window, longest_window;
  logic [LEN_W-1:0]           items_seen;
  logic signed [WEIGHT_W-1:0] recent_weights [MAX_WINDOW];
  logic [LEN_W-1:0]           k;
  logic [BACK_W-1:0]          back;
  logic                       flush;
  logic signed [SUM_W-1:0]    sum;

  logic [LEN_W-1:0]           lo, hi, seen_next, n_flush, back_first;
  logic                       active, k_is_hi, tap_ok;
  logic [LEN_W-1:0]           idx;
  logic signed [SUM_W-1:0]    sum_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      shortest_window <= LEN_W'(1);
      longest_window  <= LEN_W'(1);
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_SHORTEST: shortest_window <= cfg_data;
        CFG_LONGEST:  longest_window  <= cfg_data;
        default:      shortest_window <= shortest_window;
      endcase
    end
  end

  always_comb begin
    lo        = (shortest_window == '0) ? LEN_W'(1) : shortest_window;
    hi        = (longest_window > LEN_W'(MAX_WINDOW)) ? LEN_W'(MAX_WINDOW) : longest_window;
    active    = (hi != '0) && (lo <= hi);
    seen_next = (items_seen == LEN_W'(MAX_WINDOW)) ? items_seen : items_seen + LEN_W'(1);
    n_flush   = (seen_next < hi) ? seen_next : hi;
    back_first = item.ends_sequence ? n_flush - LEN_W'(1) : hi - LEN_W'(1);
  end

  always_comb begin
    k_is_hi  = (k == hi);
    tap_ok   = (k <= ({1'b0, back} + LEN_W'(1)));
    idx      = {1'b0, back} + LEN_W'(1) - k;
    sum_next = sum + (tap_ok ? SUM_W'(recent_weights[idx[BACK_W-1:0]]) : '0);
    status.work       = active && (item.ends_sequence || (seen_next >= hi));
    status.final_step = k_is_hi && (!flush || (back == '0));
    status.advance    = advance;
    req.valid = cmd.step && (k >= lo);
    req.sum   = sum_next;
    req.len   = k;
    req.last  = status.final_step;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      items_seen <= '0;
    end else if (cmd.load) begin
      items_seen <= item.ends_sequence ? '0 : seen_next;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      for (int i = MAX_WINDOW - 1; i > 0; i--) begin
        recent_weights[i] <= recent_weights[i-1];
      end
      recent_weights[0] <= item.weight;
      flush <= item.ends_sequence;
      back  <= back_first[BACK_W-1:0];
      k     <= LEN_W'(1);
      sum   <= '0;
    end else if (cmd.step) begin
      if (k_is_hi) begin
        k    <= LEN_W'(1);
        sum  <= '0;
        back <= back - BACK_W'(1);
      end else begin
        k   <= k + LEN_W'(1);
        sum <= sum_next;
      end
    end
  end

endmodule

// ===== hw/rtl/mwm_divider.sv =====
// rounded division pipeline by reciprocal multiply with result register
module mwm_divider import mwm_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  div_req_t req,
  output logic     advance,
  mwm_stream_if.source results
);

  logic                    v1, v2, ov;
  logic                    neg1, neg2, last1, last2;
  logic [LEN_W-1:0]        len1, len2;
  logic [NUM_W-1:0]        num1;
  logic [PROD_W-1:0]       prod2;
  logic signed [SUM_W-1:0] mag;
  logic [WEIGHT_W-1:0]     q;
  out_item_t               out_reg;

  assign advance = !ov || results.ready;
  assign mag     = (req.sum < 0) ? -req.sum : req.sum;
  assign q       = prod2[RECIP_SH +: WEIGHT_W];

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      ov <= 1'b0;
    end else if (advance) begin
      v1 <= req.valid;
      v2 <= v1;
      ov <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      neg1  <= req.sum[SUM_W-1];
      num1  <= NUM_W'(mag) + NUM_W'(req.len >> 1);
      len1  <= req.len;
      last1 <= req.last;
      neg2  <= neg1;
      prod2 <= PROD_W'(num1) * PROD_W'(recip(len1));
      len2  <= len1;
      last2 <= last1;
      out_reg.mean          <= neg2 ? WEIGHT_W'(16'd0 - q) : q;
      out_reg.window_length <= len2;
      out_reg.last_of_run   <= last2;
    end
  end

  assign results.valid   = ov;
  assign results.payload = out_reg;

endmodule

// ===== hw/rtl/multi_window_mean_core.sv =====
// top level of the multi-window mean core
//
//   channel   dir  handshake      payload
//   items     in   valid/ready    weight, ends_sequence
//   results   out  valid/ready    mean, window_length, last_of_run
//   cfg       in   cfg_we         cfg_index, cfg_data
//
// an item is taken only while the core is idle; an item that releases no start leaves
// it idle, each start released runs the length sequencer, one window length per cycle
// while the result register is not stalled, and a sequence end runs every pending start
// results pass through the three-stage reciprocal divider after their step
// a stalled result register freezes the sequencer and divider together
// reset is synchronous and leaves the core idle with both lengths at one
module multi_window_mean_core import mwm_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_we,
  input  logic             cfg_index,
  input  logic [LEN_W-1:0] cfg_data,
  mwm_stream_if.sink       items,
  mwm_stream_if.source     results
);

  ctrl_cmd_t  cmd;
  dp_status_t status;
  div_req_t   req;
  logic       advance;
  in_item_t   item;

  assign item = items.payload;

  mwm_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (items.valid),
    .status   (status),
    .cmd      (cmd),
    .ready    (items.ready)
  );

  mwm_datapath u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .item      (item),
    .cmd       (cmd),
    .advance   (advance),
    .status    (status),
    .req       (req)
  );

  mwm_divider u_divider (
    .clk     (clk),
    .rst     (rst),
    .req     (req),
    .advance (advance),
    .results (results)
  );

endmodule

// ===== hw/rtl/mwm_checker.sv =====
// port-level checker for the multi-window mean core, with its bind
`include "multi_window_mean_core_macros.svh"

module mwm_checker import mwm_pkg::*; (
  input logic      clk,
  input logic      rst,
  input logic      items_ready,
  input logic      results_valid,
  input logic      results_ready,
  input out_item_t results_payload
);

  `MWM_ASSERT_NEXT(a_stall_holds, results_valid && !results_ready, results_valid && $stable(results_payload))
  `MWM_ASSERT_NOW(a_length_range, results_valid, (results_payload.window_length != '0) && (results_payload.window_length <= LEN_W'(MAX_WINDOW)))
  `MWM_ASSERT_RESET(a_reset_idle, rst, items_ready && !results_valid)

endmodule

bind multi_window_mean_core mwm_checker u_mwm_checker (
  .clk             (clk),
  .rst             (rst),
  .items_ready     (items.ready),
  .results_valid   (results.valid),
  .results_ready   (results.ready),
  .results_payload (results.payload)
);
